// ===== rtl/core/ilsv_pkg.sv =====
// ----------------------------------------------------------------------------
// ilsv_pkg
// Types, constants and a helper function shared by the learning switch core.
// ----------------------------------------------------------------------------
package ilsv_pkg;

    localparam int TABLE_ENTRIES_DEF = 32;
    localparam int MAX_RESULTS       = 32;
    localparam int CNT_W             = $clog2(MAX_RESULTS);

    localparam int IN_DATA_W  = 208;
    localparam int OUT_DATA_W = 64;

    localparam logic [47:0] MAC_BLOCK_A = 48'h0180C2000000;
    localparam logic [47:0] MAC_BLOCK_B = 48'h01005E0000FB;
    localparam logic [15:0] ETH_VLAN    = 16'h8100;
    localparam logic [15:0] ETH_ARP     = 16'h0806;
    localparam logic [15:0] ETH_IPV4    = 16'h0800;
    localparam logic [15:0] ARP_REQUEST = 16'd1;
    localparam logic [15:0] ARP_REPLY   = 16'd2;
    localparam logic [3:0]  MCAST_NIB   = 4'hE;

    localparam logic [2:0] ACT_IGNORE    = 3'd0;
    localparam logic [2:0] ACT_BLOCK     = 3'd1;
    localparam logic [2:0] ACT_UNICAST   = 3'd2;
    localparam logic [2:0] ACT_IPFLOW    = 3'd3;
    localparam logic [2:0] ACT_FLOOD_ONE = 3'd4;
    localparam logic [2:0] ACT_FLOOD_ALL = 3'd5;

    localparam logic [1:0] VA_NONE = 2'd0;
    localparam logic [1:0] VA_SET  = 2'd1;
    localparam logic [1:0] VA_POP  = 2'd2;
    localparam logic [1:0] VA_PUSH = 2'd3;

    typedef struct packed {
        logic [31:0] ingress_port;
        logic [31:0] target_ip;
        logic [31:0] source_ip;
        logic [15:0] arp_op;
        logic [11:0] tag_vid;
        logic [15:0] inner_type;
        logic [15:0] outer_type;
        logic [47:0] dest_mac;
    } t_in;

    typedef struct packed {
        logic [11:0] match_vid;
        logic        match_vid_valid;
        logic [31:0] egress_port;
        logic [11:0] new_vid;
        logic [1:0]  vlan_action;
        logic [2:0]  action_kind;
    } t_result;

    typedef struct packed {
        logic [31:0] addr;
        logic [31:0] port;
        logic        has_tag;
        logic [11:0] vid;
    } t_entry;

    // VLAN translation from destination (dt) and source (st) tagging.
    function automatic logic [1:0] xlate(input logic dt, input logic st);
        logic [1:0] va;
        if (dt && st) begin
            va = VA_SET;
        end else if (st) begin
            va = VA_POP;
        end else if (dt) begin
            va = VA_PUSH;
        end else begin
            va = VA_NONE;
        end
        return va;
    endfunction

endpackage

// ===== rtl/core/ilsv_table.sv =====
// ----------------------------------------------------------------------------
// ilsv_table
// Address table: one write port, one registered read port, valid flags in
// flip-flops that reset clears.
// ----------------------------------------------------------------------------
module ilsv_table #(
    parameter int TABLE_ENTRIES = ilsv_pkg::TABLE_ENTRIES_DEF,
    parameter int IW            = $clog2(TABLE_ENTRIES)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr_en,
    input  logic [IW-1:0]    i_wr_idx,
    input  ilsv_pkg::t_entry i_wr_entry,
    input  logic [IW-1:0]    i_rd_idx,
    output logic             o_rd_valid,
    output ilsv_pkg::t_entry o_rd_entry
);
    import ilsv_pkg::*;

    t_entry                   r_mem [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] r_valid;
    logic                     r_rd_valid;
    t_entry                   r_rd_entry;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_idx] <= i_wr_entry;
        end
        r_rd_entry <= r_mem[i_rd_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_idx] <= 1'b1;
            end
            r_rd_valid <= r_valid[i_rd_idx];
        end
    end

    assign o_rd_valid = r_rd_valid;
    assign o_rd_entry = r_rd_entry;

endmodule

// ===== rtl/core/ip_learning_switch_vlan_unit.sv =====
// ----------------------------------------------------------------------------
// ip_learning_switch_vlan_unit
// IPv4 learning switch with VLAN translation: learns source addresses into
// a table and emits the controller actions for each packet header event.
// ----------------------------------------------------------------------------
// Ignored and reserved-MAC events go from S_DEC to S_EMIT, which loads the result that drives m_axis_tvalid.
// Known destinations: every entry is scanned in S_RD and S_CMP, then S_LEARN, S_DECIDE and S_EMIT follow.
// Floods: a second pass in S_FRD and S_FCMP gives a result per other valid entry, then S_FALL and S_EMIT the flood-all.
// s_axis_tready rises with the final result, so one event is handled at a time.
// Synchronous reset clears all valid flags at once; no clearing pass.
module ip_learning_switch_vlan_unit #(
    parameter int TABLE_ENTRIES = ilsv_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // dest_mac, outer_type, inner_type, tag_vid, arp_op, source_ip,
    // target_ip, ingress_port (lowest bit up), 4 zero bits on top
    input  logic [ilsv_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // action_kind, vlan_action, new_vid, egress_port, match_vid_valid,
    // match_vid (lowest bit up), 2 zero bits on top
    output logic [ilsv_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    output logic                            m_axis_tlast
);
    import ilsv_pkg::*;

    localparam int IW = $clog2(TABLE_ENTRIES);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DEC    = 4'd1;
    localparam logic [3:0] S_RD     = 4'd2;
    localparam logic [3:0] S_CMP    = 4'd3;
    localparam logic [3:0] S_LEARN  = 4'd4;
    localparam logic [3:0] S_DECIDE = 4'd5;
    localparam logic [3:0] S_FRD    = 4'd6;
    localparam logic [3:0] S_FCMP   = 4'd7;
    localparam logic [3:0] S_FALL   = 4'd8;
    localparam logic [3:0] S_EMIT   = 4'd9;

    logic [3:0]       r_state, n_state;
    logic [IW-1:0]    r_idx, n_idx;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    t_in              r_in, n_in;
    logic             r_s_found, n_s_found;
    logic             r_s_tag, n_s_tag;
    logic [11:0]      r_s_vid, n_s_vid;
    logic             r_d_found, n_d_found;
    logic [31:0]      r_d_port, n_d_port;
    logic             r_d_tag, n_d_tag;
    logic [11:0]      r_d_vid, n_d_vid;
    logic             r_free_found, n_free_found;
    logic [IW-1:0]    r_free_idx, n_free_idx;
    t_result          r_res, n_res;
    logic             r_o_valid;
    t_result          r_o_res;
    logic             r_o_last;

    logic             wr_en;
    t_entry           wr_entry;
    logic             rd_valid;
    t_entry           rd_entry;
    logic             o_load;
    t_result          o_res;
    logic             o_last;

    logic             has_tag;
    logic [15:0]      etype;
    logic             is_block;
    logic             is_arp;
    logic             is_ip;
    logic             last_idx;
    logic             out_free;
    logic             hit;

    ilsv_table #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .IW            (IW)
    ) u_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (wr_en),
        .i_wr_idx   (r_free_idx),
        .i_wr_entry (wr_entry),
        .i_rd_idx   (r_idx),
        .o_rd_valid (rd_valid),
        .o_rd_entry (rd_entry)
    );

    assign has_tag  = (r_in.outer_type == ETH_VLAN);
    assign etype    = has_tag ? r_in.inner_type : r_in.outer_type;
    assign is_block = (r_in.dest_mac == MAC_BLOCK_A) || (r_in.dest_mac == MAC_BLOCK_B);
    assign is_arp   = (etype == ETH_ARP) &&
                      ((r_in.arp_op == ARP_REQUEST) || (r_in.arp_op == ARP_REPLY));
    assign is_ip    = (etype == ETH_IPV4);
    assign last_idx = (r_idx == IW'(TABLE_ENTRIES - 1));
    assign out_free = !r_o_valid || m_axis_tready;
    assign hit      = rd_valid && (rd_entry.addr != r_in.source_ip);

    assign wr_entry.addr    = r_in.source_ip;
    assign wr_entry.port    = r_in.ingress_port;
    assign wr_entry.has_tag = has_tag;
    assign wr_entry.vid     = has_tag ? r_in.tag_vid : 12'd0;

    assign s_axis_tready = (r_state == S_IDLE);

    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_cnt        = r_cnt;
        n_in         = r_in;
        n_s_found    = r_s_found;
        n_s_tag      = r_s_tag;
        n_s_vid      = r_s_vid;
        n_d_found    = r_d_found;
        n_d_port     = r_d_port;
        n_d_tag      = r_d_tag;
        n_d_vid      = r_d_vid;
        n_free_found = r_free_found;
        n_free_idx   = r_free_idx;
        n_res        = r_res;
        wr_en        = 1'b0;
        o_load       = 1'b0;
        o_res        = r_res;
        o_last       = 1'b1;
        case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_in    = t_in'(s_axis_tdata[$bits(t_in)-1:0]);
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                n_s_found    = 1'b0;
                n_s_tag      = 1'b0;
                n_s_vid      = 12'd0;
                n_d_found    = 1'b0;
                n_free_found = 1'b0;
                n_idx        = '0;
                n_res        = '0;
                if (is_block) begin
                    n_res.action_kind = ACT_BLOCK;
                    n_state           = S_EMIT;
                end else if (!is_arp && !is_ip) begin
                    n_res.action_kind = ACT_IGNORE;
                    n_state           = S_EMIT;
                end else begin
                    n_state = S_RD;
                end
            end
            S_RD: begin
                n_state = S_CMP;
            end
            S_CMP: begin
                // The read data belongs to the entry at r_idx.
                if (rd_valid && rd_entry.addr == r_in.source_ip && !r_s_found) begin
                    n_s_found = 1'b1;
                    n_s_tag   = rd_entry.has_tag;
                    n_s_vid   = rd_entry.vid;
                end
                if (rd_valid && rd_entry.addr == r_in.target_ip && !r_d_found) begin
                    n_d_found = 1'b1;
                    n_d_port  = rd_entry.port;
                    n_d_tag   = rd_entry.has_tag;
                    n_d_vid   = rd_entry.vid;
                end
                if (!rd_valid && !r_free_found) begin
                    n_free_found = 1'b1;
                    n_free_idx   = r_idx;
                end
                if (last_idx) begin
                    n_state = S_LEARN;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = S_RD;
                end
            end
            S_LEARN: begin
                if (!r_s_found && r_free_found) begin
                    wr_en     = 1'b1;
                    n_s_found = 1'b1;
                    n_s_tag   = has_tag;
                    n_s_vid   = wr_entry.vid;
                    // A target equal to the source hits the entry just learned.
                    if (r_in.target_ip == r_in.source_ip) begin
                        n_d_found = 1'b1;
                        n_d_port  = r_in.ingress_port;
                        n_d_tag   = has_tag;
                        n_d_vid   = wr_entry.vid;
                    end
                end
                n_state = S_DECIDE;
            end
            S_DECIDE: begin
                if (!r_d_found || (is_arp && r_in.target_ip[31:28] == MCAST_NIB)) begin
                    n_idx   = '0;
                    n_cnt   = '0;
                    n_state = S_FRD;
                end else begin
                    n_res.action_kind     = is_arp ? ACT_UNICAST : ACT_IPFLOW;
                    n_res.vlan_action     = xlate(r_d_tag, r_s_tag);
                    n_res.new_vid         = r_d_tag ? r_d_vid : 12'd0;
                    n_res.egress_port     = r_d_port;
                    n_res.match_vid_valid = !is_arp && r_s_tag;
                    n_res.match_vid       = (!is_arp && r_s_tag) ? r_s_vid : 12'd0;
                    n_state               = S_EMIT;
                end
            end
            S_FRD: begin
                n_state = S_FCMP;
            end
            S_FCMP: begin
                o_res.action_kind     = ACT_FLOOD_ONE;
                o_res.vlan_action     = xlate(rd_entry.has_tag, r_s_tag);
                o_res.new_vid         = rd_entry.has_tag ? rd_entry.vid : 12'd0;
                o_res.egress_port     = rd_entry.port;
                o_res.match_vid_valid = 1'b0;
                o_res.match_vid       = 12'd0;
                o_last                = 1'b0;
                if (hit) begin
                    if (out_free) begin
                        o_load = 1'b1;
                        n_cnt  = r_cnt + 1'b1;
                        // Keep one place for the closing flood-all.
                        if (last_idx || r_cnt == CNT_W'(MAX_RESULTS - 2)) begin
                            n_state = S_FALL;
                        end else begin
                            n_idx   = r_idx + 1'b1;
                            n_state = S_FRD;
                        end
                    end
                end else if (last_idx) begin
                    n_state = S_FALL;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = S_FRD;
                end
            end
            S_FALL: begin
                n_res             = '0;
                n_res.action_kind = ACT_FLOOD_ALL;
                n_res.vlan_action = r_s_tag ? VA_POP : VA_NONE;
                n_state           = S_EMIT;
            end
            S_EMIT: begin
                if (out_free) begin
                    o_load  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_load) begin
                r_o_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx        <= n_idx;
        r_cnt        <= n_cnt;
        r_in         <= n_in;
        r_s_found    <= n_s_found;
        r_s_tag      <= n_s_tag;
        r_s_vid      <= n_s_vid;
        r_d_found    <= n_d_found;
        r_d_port     <= n_d_port;
        r_d_tag      <= n_d_tag;
        r_d_vid      <= n_d_vid;
        r_free_found <= n_free_found;
        r_free_idx   <= n_free_idx;
        r_res        <= n_res;
        if (o_load) begin
            r_o_res  <= o_res;
            r_o_last <= o_last;
        end
    end

    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = {{(OUT_DATA_W - $bits(t_result)){1'b0}}, r_o_res};
    assign m_axis_tlast  = r_o_last;

endmodule

// ===== rtl/core/ilsv_checker.sv =====
// ----------------------------------------------------------------------------
// ilsv_checker
// Port-level checks on the learning switch core, bound to its top level.
// ----------------------------------------------------------------------------
module ilsv_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [ilsv_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input logic                            m_axis_tlast
);
    import ilsv_pkg::*;

    logic [2:0] kind;
    logic       in_txn;

    assign kind   = m_axis_tdata[2:0];
    assign in_txn = s_axis_tvalid && s_axis_tready;

    // A stalled result keeps its contents.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("result changed while stalled");

    // Events are handled one at a time.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_txn |=> !s_axis_tready)
        else $error("input taken while busy");

    // Only per-entry flood results are followed by more results.
    a_flood_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && kind == ACT_FLOOD_ONE |-> !m_axis_tlast)
        else $error("flood to entry marked last");

    a_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && kind != ACT_FLOOD_ONE |-> m_axis_tlast)
        else $error("final result not marked last");

endmodule

bind ip_learning_switch_vlan_unit ilsv_checker u_ilsv_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

// ===== sim/ilsv_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ilsv_tb_checker
// Watches both streams of the learning switch, predicts the actions of each
// accepted header event from its own copy of the address table, and compares
// every result transaction field by field with the oldest expected one.
// ----------------------------------------------------------------------------
module ilsv_tb_checker #(
    parameter int TABLE_ENTRIES = ilsv_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  logic                            i_in_ready,
    input  logic [ilsv_pkg::IN_DATA_W-1:0]  i_in_data,
    input  logic                            i_out_valid,
    input  logic                            i_out_ready,
    input  logic [ilsv_pkg::OUT_DATA_W-1:0] i_out_data,
    input  logic                            i_out_last,
    output int                              o_errors,
    output int                              o_pending
);
    import ilsv_pkg::*;

    typedef struct packed {
        t_result    res;
        logic       last;
    } t_action;

    t_action    actions_due[$];
    logic       tbl_valid [TABLE_ENTRIES];
    t_entry     tbl [TABLE_ENTRIES];
    int         errors;

    assign o_errors  = errors;
    assign o_pending = actions_due.size();

    function automatic logic [1:0] vlan_xlate(logic dt, logic st);
        if (dt && st) return VA_SET;
        if (st)       return VA_POP;
        if (dt)       return VA_PUSH;
        return VA_NONE;
    endfunction

    function automatic int lookup(logic [31:0] addr);
        for (int i = 0; i < TABLE_ENTRIES; i++)
            if (tbl_valid[i] && tbl[i].addr == addr) return i;
        return -1;
    endfunction

    task automatic push_action(logic [2:0] kind, logic [1:0] va, logic [11:0] vid,
                               logic [31:0] port, logic mv, logic [11:0] mvid,
                               logic last);
        t_action a;
        a.res.action_kind     = kind;
        a.res.vlan_action     = va;
        a.res.new_vid         = vid;
        a.res.egress_port     = port;
        a.res.match_vid_valid = mv;
        a.res.match_vid       = mvid;
        a.last                = last;
        actions_due.push_back(a);
    endtask

    task automatic predict_event(t_in ev);
        logic       has_tag;
        logic [15:0] etype;
        logic       is_arp;
        int         s, d, n;
        logic       st, dt;
        has_tag = (ev.outer_type == ETH_VLAN);
        etype   = has_tag ? ev.inner_type : ev.outer_type;
        if (ev.dest_mac == MAC_BLOCK_A || ev.dest_mac == MAC_BLOCK_B) begin
            push_action(ACT_BLOCK, VA_NONE, 12'd0, 32'd0, 1'b0, 12'd0, 1'b1);
            return;
        end
        if (etype == ETH_ARP && (ev.arp_op == ARP_REQUEST || ev.arp_op == ARP_REPLY)) begin
            is_arp = 1'b1;
        end else if (etype == ETH_IPV4) begin
            is_arp = 1'b0;
        end else begin
            push_action(ACT_IGNORE, VA_NONE, 12'd0, 32'd0, 1'b0, 12'd0, 1'b1);
            return;
        end
        s = lookup(ev.source_ip);
        if (s < 0) begin
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                if (!tbl_valid[i]) begin
                    tbl_valid[i]   = 1'b1;
                    tbl[i].addr    = ev.source_ip;
                    tbl[i].port    = ev.ingress_port;
                    tbl[i].has_tag = has_tag;
                    tbl[i].vid     = has_tag ? ev.tag_vid : 12'd0;
                    s = i;
                    break;
                end
            end
        end
        st = (s >= 0) ? tbl[s].has_tag : 1'b0;
        d = lookup(ev.target_ip);
        if (d < 0 || (is_arp && ev.target_ip[31:28] == MCAST_NIB)) begin
            n = 0;
            for (int i = 0; i < TABLE_ENTRIES && n < MAX_RESULTS - 1; i++) begin
                if (!tbl_valid[i] || tbl[i].addr == ev.source_ip) continue;
                dt = tbl[i].has_tag;
                push_action(ACT_FLOOD_ONE, vlan_xlate(dt, st), dt ? tbl[i].vid : 12'd0,
                            tbl[i].port, 1'b0, 12'd0, 1'b0);
                n++;
            end
            push_action(ACT_FLOOD_ALL, st ? VA_POP : VA_NONE, 12'd0, 32'd0, 1'b0, 12'd0,
                        1'b1);
            return;
        end
        dt = tbl[d].has_tag;
        if (is_arp)
            push_action(ACT_UNICAST, vlan_xlate(dt, st), dt ? tbl[d].vid : 12'd0,
                        tbl[d].port, 1'b0, 12'd0, 1'b1);
        else
            push_action(ACT_IPFLOW, vlan_xlate(dt, st), dt ? tbl[d].vid : 12'd0,
                        tbl[d].port, st, st ? tbl[s].vid : 12'd0, 1'b1);
    endtask

    always @(posedge i_clk) begin
        t_action exp_a;
        t_result got;
        if (!i_rst_n) begin
            for (int i = 0; i < TABLE_ENTRIES; i++) tbl_valid[i] = 1'b0;
            actions_due.delete();
            errors = 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                got = i_out_data[$bits(t_result)-1:0];
                if (actions_due.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected result transaction %h last %b", got, i_out_last);
                end else begin
                    exp_a = actions_due.pop_front();
                    if (got !== exp_a.res || i_out_last !== exp_a.last
                        || i_out_data[OUT_DATA_W-1:$bits(t_result)] !== '0) begin
                        errors++;
                        if (errors <= 10) begin
                            $display("mismatch: expected kind %0d va %0d vid %h port %h %s",
                                exp_a.res.action_kind, exp_a.res.vlan_action,
                                exp_a.res.new_vid, exp_a.res.egress_port, "");
                            $display("  expected mv %b mvid %h last %b",
                                exp_a.res.match_vid_valid, exp_a.res.match_vid, exp_a.last);
                            $display("  got kind %0d va %0d vid %h port %h mv %b mvid %h last %b",
                                got.action_kind, got.vlan_action, got.new_vid,
                                got.egress_port, got.match_vid_valid, got.match_vid,
                                i_out_last);
                        end
                    end
                end
            end
            if (i_in_valid && i_in_ready)
                predict_event(t_in'(i_in_data[$bits(t_in)-1:0]));
        end
    end

endmodule

// ===== sim/tb_ip_learning_switch_vlan_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ip_learning_switch_vlan_unit
// Drives directed and random packet header events into the learning switch,
// with random idling on both streams; the checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_ip_learning_switch_vlan_unit;
    import ilsv_pkg::*;

    localparam int WATCHDOG = 20000;

    logic                  i_clk = 0;
    logic                  i_rst_n = 0;
    logic                  s_axis_tvalid = 0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tlast;
    int                    errors, pending;
    int                    idle_cnt = 0;
    bit                    calm;
    logic [31:0]           addr_pool [8];

    always #6 i_clk = ~i_clk;

    ip_learning_switch_vlan_unit dut (.*);

    ilsv_tb_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(s_axis_tvalid), .i_in_ready(s_axis_tready), .i_in_data(s_axis_tdata),
        .i_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready),
        .i_out_data(m_axis_tdata), .i_out_last(m_axis_tlast),
        .o_errors(errors), .o_pending(pending)
    );

    // Receiver stalls in bursts until the calm final stretch.
    always @(posedge i_clk) begin
        int burst;
        if (calm) begin
            m_axis_tready <= 1;
        end else if (burst > 0) begin
            burst--;
            m_axis_tready <= 0;
        end else if ($urandom_range(0, 5) == 0) begin
            burst = $urandom_range(1, 11);
            m_axis_tready <= 0;
        end else begin
            m_axis_tready <= 1;
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cnt <= 0;
        else
            idle_cnt <= idle_cnt + 1;
        if (idle_cnt >= WATCHDOG) begin
            $display("tb_ip_learning_switch_vlan_unit failed");
            $finish;
        end
    end

    // Returns at the accepting edge with tvalid still high.
    task automatic send_event(t_in ev);
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_DATA_W'(ev);
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    function automatic t_in make_event(logic [15:0] et, logic tag, logic [15:0] op,
                                       logic [31:0] sip, logic [31:0] tip);
        t_in ev;
        ev.dest_mac     = 48'({$urandom, $urandom});
        ev.tag_vid      = 12'($urandom);
        ev.arp_op       = op;
        ev.source_ip    = sip;
        ev.target_ip    = tip;
        ev.ingress_port = $urandom;
        ev.outer_type   = tag ? ETH_VLAN : et;
        ev.inner_type   = tag ? et : 16'($urandom);
        return ev;
    endfunction

    initial begin
        t_in ev;
        int  r;
        calm = 0;
        for (int i = 0; i < 8; i++) addr_pool[i] = $urandom;
        addr_pool[7] = 32'hE00000FB;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed: reserved MACs, ignored kinds, ARP ops, learning, lookups.
        ev = make_event(ETH_IPV4, 1'b0, 16'd0, 32'd1, 32'd2);
        ev.dest_mac = MAC_BLOCK_A; send_event(ev);
        ev = make_event(ETH_ARP, 1'b1, ARP_REQUEST, 32'd1, 32'd2);
        ev.dest_mac = MAC_BLOCK_B; send_event(ev);
        send_event(make_event(16'h86DD, 1'b0, ARP_REQUEST, 32'd1, 32'd2));
        send_event(make_event(ETH_ARP, 1'b0, 16'd3, 32'd1, 32'd2));
        send_event(make_event(ETH_ARP, 1'b0, 16'hFFFF, 32'd1, 32'd2));
        ev = make_event(ETH_VLAN, 1'b0, ARP_REQUEST, 32'd1, 32'd2); send_event(ev);
        send_event(make_event(ETH_ARP, 1'b1, ARP_REQUEST, 32'h0, 32'hFFFFFFFF));
        send_event(make_event(ETH_ARP, 1'b0, ARP_REPLY, 32'hFFFFFFFF, 32'h0));
        send_event(make_event(ETH_IPV4, 1'b1, 16'd0, 32'h0A000001, 32'h0));
        send_event(make_event(ETH_IPV4, 1'b0, 16'd0, 32'h0A000002, 32'h0A000001));
        send_event(make_event(ETH_IPV4, 1'b1, 16'd0, 32'h0A000001, 32'h0A000002));
        send_event(make_event(ETH_IPV4, 1'b0, 16'd0, 32'h0A000002, 32'h0A000002));
        send_event(make_event(ETH_ARP, 1'b1, ARP_REQUEST, 32'h0A000001, 32'hEFFFFFFF));
        send_event(make_event(ETH_IPV4, 1'b0, 16'd0, 32'h0A000002, 32'hE0000000));
        ev = make_event(ETH_IPV4, 1'b1, 16'd0, 32'h0A000003, 32'h0A000001);
        ev.tag_vid = 12'hFFF; ev.ingress_port = 32'hFFFFFFFF; send_event(ev);
        ev = make_event(ETH_ARP, 1'b0, ARP_REQUEST, 32'h0A000004, 32'h0A000003);
        ev.dest_mac = 48'hFFFFFFFFFFFF; ev.ingress_port = 32'd0; send_event(ev);

        // Wait for the table to settle before filling it past full.
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        for (int i = 0; i < 34; i++)
            send_event(make_event(ETH_IPV4, 1'($urandom_range(0, 1)), 16'd0,
                                  32'hC0A80000 + 32'(i), 32'h01010101));
        send_event(make_event(ETH_ARP, 1'b1, ARP_REQUEST, 32'h77777777, 32'hE1234567));
        send_event(make_event(ETH_IPV4, 1'b1, 16'd0, 32'h77777777, 32'hC0A80005));
        send_event(make_event(ETH_IPV4, 1'b0, 16'd0, 32'hC0A80006, 32'hC0A80005));

        for (int i = 0; i < 50; i++) begin
            if (i == 40) calm = 1;
            r = $urandom_range(0, 9);
            if (r < 8)
                ev = make_event(($urandom_range(0, 1)) ? ETH_ARP : ETH_IPV4,
                                1'($urandom_range(0, 1)), 16'($urandom_range(1, 2)),
                                addr_pool[3'($urandom_range(0, 7))],
                                ($urandom_range(0, 3) == 0) ? 32'($urandom)
                                                            : addr_pool[3'($urandom_range(0, 7))]);
            else
                ev = t_in'($bits(t_in)'({$urandom, $urandom, $urandom, $urandom, $urandom,
                                         $urandom, $urandom}));
            if ($urandom_range(0, 30) == 0) ev.dest_mac = MAC_BLOCK_A;
            send_event(ev);
        end

        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (errors == 0)
            $display("tb_ip_learning_switch_vlan_unit passed");
        else
            $display("tb_ip_learning_switch_vlan_unit failed");
        $finish;
    end

endmodule
